// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/idrc_pkg.sv =====
// ----------------------------------------------------------------------------
// idrc_pkg
// Types, constants and helper functions of the ID resistor classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package idrc_pkg;

  localparam int SAMPLES_PER_BATCH = 5;
  localparam int SAMPLE_W          = 21;
  localparam int CLASS_W           = 3;
  localparam int JIG_W             = 2;
  localparam int NUM_THR           = 6;
  localparam int CFG_IDX_W         = 3;

  localparam int CNT_W = $clog2(SAMPLES_PER_BATCH);
  localparam int KEEP  = SAMPLES_PER_BATCH - 2;
  localparam int SUM_W = SAMPLE_W + $clog2(KEEP);

  // divide by KEEP as multiply by rounded-up reciprocal; exact for sum < 2^SUM_W
  localparam int DIV_SHIFT = SUM_W + 2;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(KEEP) - 64'd1) / 64'(KEEP));
  localparam int PROD_W = SUM_W + RECIP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_56K  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_255K = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_301K = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_523K = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_619K = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_OPEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTORY  = 3'd6;

  // classes
  localparam logic [CLASS_W-1:0] CLS_GND  = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_56K  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_255K = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_301K = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_523K = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_619K = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_OPEN = 3'd6;

  // jig line actions
  localparam logic [JIG_W-1:0] JIG_LEAVE = 2'd0;
  localparam logic [JIG_W-1:0] JIG_LOW   = 2'd1;
  localparam logic [JIG_W-1:0] JIG_HIGH  = 2'd2;

  typedef logic [NUM_THR-1:0][SAMPLE_W-1:0] thr_arr_t;

  localparam thr_arr_t THR_RESET = {
    21'd750000, 21'd390000, 21'd290000, 21'd210000, 21'd100000, 21'd30000
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_uv;
    logic                read_error;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_uv;
    logic [CLASS_W-1:0]  id_class;
    logic [JIG_W-1:0]    jig_action;
    logic                read_failed;
  } out_t;

  typedef struct packed {
    logic store_wr;
    logic cnt_clr;
    logic cnt_inc;
    logic scan_init;
    logic scan_step;
    logic sum_step;
    logic mul_en;
    logic load_res;
    logic load_err;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic idx_last;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_SCAN,
    ST_SUM,
    ST_MUL,
    ST_FIN
  } state_e;

  // first threshold the average is below, open if none
  function automatic logic [CLASS_W-1:0] classify(input logic [SAMPLE_W-1:0] avg,
                                                  input thr_arr_t thr);
    logic [CLASS_W-1:0] cls;
    logic               hit;
    cls = CLS_OPEN;
    hit = 1'b0;
    for (int c = 0; c < NUM_THR; c++) begin
      if (!hit && (avg < thr[c])) begin
        cls = CLASS_W'(c);
        hit = 1'b1;
      end
    end
    return cls;
  endfunction

  function automatic logic [JIG_W-1:0] jig_for(input logic [CLASS_W-1:0] cls,
                                               input logic factory);
    logic [JIG_W-1:0] jig;
    jig = JIG_LEAVE;
    if ((cls == CLS_301K) || (cls == CLS_619K)) begin
      jig = JIG_LOW;
    end else if ((cls == CLS_523K) && factory) begin
      jig = JIG_HIGH;
    end
    return jig;
  endfunction

endpackage

// ===== rtl/core/idrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// idrc_ctrl
// Sequencer: batch intake, min/max scan, trimmed sum, divide, result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idrc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_error_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  idrc_pkg::sts_t sts_i,
  output idrc_pkg::cmd_t cmd_o
);
  import idrc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_error_i) begin
            if (!out_free) state_d = ST_ERR;
          end else if (sts_i.cnt_last) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_ERR:  if (out_free) state_d = ST_IDLE;
      ST_SCAN: if (sts_i.idx_last) state_d = ST_SUM;
      ST_SUM:  if (sts_i.idx_last) state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_error_i) begin
            cmd_o.cnt_clr  = 1'b1;
            cmd_o.load_err = out_free;
          end else begin
            cmd_o.store_wr = 1'b1;
            if (sts_i.cnt_last) begin
              cmd_o.cnt_clr   = 1'b1;
              cmd_o.scan_init = 1'b1;
            end else begin
              cmd_o.cnt_inc = 1'b1;
            end
          end
        end
      end
      ST_ERR:  cmd_o.load_err  = out_free;
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_SUM:  cmd_o.sum_step  = 1'b1;
      ST_MUL:  cmd_o.mul_en    = 1'b1;
      ST_FIN:  cmd_o.load_res  = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_err || cmd_o.load_res) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/idrc_dp.sv =====
// ----------------------------------------------------------------------------
// idrc_dp
// Sample store, config registers, min/max scan, sum, reciprocal divide,
// classification and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idrc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [idrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [idrc_pkg::SAMPLE_W-1:0]  cfg_wdata_i,
  input  logic [idrc_pkg::SAMPLE_W-1:0]  sample_i,
  input  idrc_pkg::cmd_t                 cmd_i,
  output idrc_pkg::sts_t                 sts_o,
  output idrc_pkg::out_t                 res_o
);
  import idrc_pkg::*;

  thr_arr_t            thr_q;
  logic                factory_q;
  logic [SAMPLE_W-1:0] store_q [SAMPLES_PER_BATCH];
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    lo_idx_q, hi_idx_q;
  logic [SAMPLE_W-1:0] lo_q, hi_q;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  out_t                res_q;
  logic [SAMPLE_W-1:0] rd_val;
  logic [SAMPLE_W-1:0] avg;
  logic [CLASS_W-1:0]  cls;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_BATCH - 1);

  assign rd_val       = store_q[idx_q];
  assign sts_o.cnt_last = (cnt_q == LAST);
  assign sts_o.idx_last = (idx_q == LAST);
  assign avg          = prod_q[DIV_SHIFT +: SAMPLE_W];
  assign cls          = classify(avg, thr_q);
  assign res_o        = res_q;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan_init) begin
      idx_d = CNT_W'(1);
    end else if (cmd_i.scan_step || cmd_i.sum_step) begin
      idx_d = sts_o.idx_last ? '0 : idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RESET;
      factory_q <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < CFG_FACTORY) begin
          thr_q[cfg_idx_i] <= cfg_wdata_i;
        end else if (cfg_idx_i == CFG_FACTORY) begin
          factory_q <= cfg_wdata_i[0];
        end
      end
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store_q[cnt_q] <= sample_i;
    end
    if (cmd_i.scan_init) begin
      lo_q     <= store_q[0];
      hi_q     <= store_q[0];
      lo_idx_q <= '0;
      hi_idx_q <= '0;
      sum_q    <= '0;
    end else if (cmd_i.scan_step) begin
      if (rd_val < lo_q) begin
        lo_q     <= rd_val;
        lo_idx_q <= idx_q;
      end else if (rd_val >= hi_q) begin
        hi_q     <= rd_val;
        hi_idx_q <= idx_q;
      end
    end else if (cmd_i.sum_step) begin
      if ((idx_q != lo_idx_q) && (idx_q != hi_idx_q)) begin
        sum_q <= sum_q + SUM_W'(rd_val);
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
    end
    if (cmd_i.load_err) begin
      res_q.average_uv  <= '0;
      res_q.id_class    <= CLS_GND;
      res_q.jig_action  <= JIG_LEAVE;
      res_q.read_failed <= 1'b1;
    end else if (cmd_i.load_res) begin
      res_q.average_uv  <= avg;
      res_q.id_class    <= cls;
      res_q.jig_action  <= jig_for(cls, factory_q);
      res_q.read_failed <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/id_resistor_trimmed_mean_classifier.sv =====
// ----------------------------------------------------------------------------
// id_resistor_trimmed_mean_classifier
// Five-sample trimmed-mean ID resistor classifier with jig-line action.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_stall_o carries one ADC reading (microvolts)
// and a read-error flag per transaction. Output channel out_valid_o/
// out_stall_i carries average, class, jig action and a read-failed flag.
// Thresholds and factory mode are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i while the block is idle: a rule for the user that the block
// itself does not enforce. A sample that does not complete the batch is
// stored and gives no result. The fifth sample starts the sequencer: a
// min/max scan and a trimmed sum over the store read port, one reciprocal
// multiply, then classification into the output register once that is
// free, the input stalled meanwhile. A read error discards the batch and
// loads its result into the output register once that is free. The
// output register lets new samples enter while a result waits; a pending
// read-error or final result holds the input stalled until the receiver
// takes the previous one. Reset restores the default thresholds, clears
// factory mode and empties the batch and the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module id_resistor_trimmed_mean_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [idrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [idrc_pkg::SAMPLE_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  idrc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output idrc_pkg::out_t                 out_data_o
);
  import idrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  idrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_error_i  (in_data_i.read_error),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  idrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (in_data_i.sample_uv),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (out_data_o)
  );

endmodule

// ===== rtl/core/idrc_chk.sv =====
// ----------------------------------------------------------------------------
// idrc_chk
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module idrc_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input idrc_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input idrc_pkg::out_t out_data_o
);
  import idrc_pkg::*;

  logic err_acc;

  assign err_acc = in_valid_i && !in_stall_o && in_data_i.read_error;

  `ASSERT_NEXT(a_err_result, err_acc && !out_valid_o, out_valid_o && out_data_o.read_failed)
  `ASSERT_IMPL(a_err_fields, out_valid_o && out_data_o.read_failed, (out_data_o.average_uv == '0) && (out_data_o.id_class == CLS_GND) && (out_data_o.jig_action == JIG_LEAVE))
  `ASSERT_IMPL(a_jig_low, out_valid_o && (out_data_o.jig_action == JIG_LOW), (out_data_o.id_class == CLS_301K) || (out_data_o.id_class == CLS_619K))
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind id_resistor_trimmed_mean_classifier idrc_chk u_idrc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five-sample trimmed-mean ID resistor classifier.
// ----------------------------------------------------------------------------
// An initial block fills a queue of ADC readings. It starts with a short
// directed set, then random batches under several threshold and factory-mode
// settings, including all-zero, all-max and non-ascending thresholds. A
// clocked driver presents the readings with random gaps. A clocked monitor
// applies random output stalls. Every accepted reading goes through an
// in-bench model of the batch store, the min/max trim, the average, the
// class and the jig action. Every accepted result is checked, field by
// field, against the oldest expected one. A watchdog ends a hung run.
// ----------------------------------------------------------------------------

module tb_top;
  import idrc_pkg::*;

  localparam int SMAX         = (1 << SAMPLE_W) - 1;
  localparam int IDLE_LIMIT   = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 110;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_THR_56K;
  logic [SAMPLE_W-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  in_t                  in_data_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  out_t                 out_data_o;

  id_resistor_trimmed_mean_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the classifier state
  logic [SAMPLE_W-1:0] thr_now [NUM_THR];
  logic                factory_now;
  logic [SAMPLE_W-1:0] batch [SAMPLES_PER_BATCH];
  int                  batch_fill = 0;

  in_t  reading_q [$];
  out_t class_q [$];

  int n_fail       = 0;
  int n_readings   = 0;
  int n_results    = 0;
  int n_err_result = 0;
  int n_settings   = 1;
  int gap_left     = 0;
  int stall_left   = 0;
  int tx_calm      = 0;
  int rx_calm      = 0;
  int idle_cycles  = 0;

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic bit predict_classification(input in_t rd, output out_t res);
    logic [SAMPLE_W-1:0] lo, hi, mean;
    int                  lo_at, hi_at;
    int unsigned         total;
    logic [CLASS_W-1:0]  cls;
    res = '0;
    if (rd.read_error) begin
      batch_fill      = 0;
      res.id_class    = CLS_GND;
      res.jig_action  = JIG_LEAVE;
      res.read_failed = 1'b1;
      return 1'b1;
    end
    batch[batch_fill] = rd.sample_uv;
    batch_fill++;
    if (batch_fill < SAMPLES_PER_BATCH) return 1'b0;
    batch_fill = 0;

    lo = batch[0];
    hi = batch[0];
    lo_at = 0;
    hi_at = 0;
    for (int k = 1; k < SAMPLES_PER_BATCH; k++) begin
      if (batch[k] < lo) begin
        lo = batch[k];
        lo_at = k;
      end else if (batch[k] >= hi) begin
        hi = batch[k];
        hi_at = k;
      end
    end
    total = 0;
    for (int k = 0; k < SAMPLES_PER_BATCH; k++) begin
      if (k != lo_at && k != hi_at) total += batch[k];
    end
    mean = SAMPLE_W'(total / KEEP);

    if (mean < thr_now[CFG_THR_56K])       cls = CLS_GND;
    else if (mean < thr_now[CFG_THR_255K]) cls = CLS_56K;
    else if (mean < thr_now[CFG_THR_301K]) cls = CLS_255K;
    else if (mean < thr_now[CFG_THR_523K]) cls = CLS_301K;
    else if (mean < thr_now[CFG_THR_619K]) cls = CLS_523K;
    else if (mean < thr_now[CFG_THR_OPEN]) cls = CLS_619K;
    else                                   cls = CLS_OPEN;

    res.average_uv = mean;
    res.id_class   = cls;
    case (cls)
      CLS_301K, CLS_619K: res.jig_action = JIG_LOW;
      CLS_523K:           res.jig_action = factory_now ? JIG_HIGH : JIG_LEAVE;
      default:            res.jig_action = JIG_LEAVE;
    endcase
    return 1'b1;
  endfunction

  // input side: one reading per transaction, random gaps between them
  always @(posedge clk_i) begin : driver
    out_t r;
    bit   holding;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      holding = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        n_readings++;
        if (predict_classification(in_data_i, r)) begin
          class_q.push_back(r);
          if (r.read_failed) n_err_result++;
        end
        holding = 1'b0;
        gap_left = draw_wait(tx_calm);
      end
      if (!holding) begin
        if (gap_left > 0 || reading_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= reading_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // output side: random stall per result
  always @(posedge clk_i) begin : monitor
    out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (class_q.size() == 0) begin
          $error("result with nothing expected: average_uv %0d class %0d",
                 out_data_o.average_uv, out_data_o.id_class);
          n_fail++;
        end else begin
          want = class_q.pop_front();
          check_field("average_uv", want.average_uv, out_data_o.average_uv);
          check_field("id_class", want.id_class, out_data_o.id_class);
          check_field("jig_action", want.jig_action, out_data_o.jig_action);
          check_field("read_failed", want.read_failed, out_data_o.read_failed);
        end
        stall_left = draw_wait(rx_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_reading(input int v, input logic err);
    in_t rd;
    rd.sample_uv  = SAMPLE_W'(v);
    rd.read_error = err;
    reading_q.push_back(rd);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_FACTORY) factory_now = val[0];
    else if (idx < CFG_FACTORY) thr_now[idx] = val;
  endtask

  task automatic configure(input logic [SAMPLE_W-1:0] t0, t1, t2, t3, t4, t5, fac);
    set_reg(CFG_THR_56K, t0);
    set_reg(CFG_THR_255K, t1);
    set_reg(CFG_THR_301K, t2);
    set_reg(CFG_THR_523K, t3);
    set_reg(CFG_THR_619K, t4);
    set_reg(CFG_THR_OPEN, t5);
    set_reg(CFG_FACTORY, fac);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // sender holds off until all results are back and the sequencer is done
  task automatic drain();
    while (reading_q.size() != 0 || in_valid_i || class_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_random_batches(input int want_items);
    int pushed, base, v, err_at;
    bit tie_mode;
    pushed = 0;
    while (pushed < want_items) begin
      case ($urandom_range(0, 3))
        0:       base = $urandom_range(0, SMAX);
        1:       base = int'(thr_now[$urandom_range(0, NUM_THR - 1)]);
        2:       base = $urandom_range(0, 800000);
        default: base = $urandom_range(0, 1) ? SMAX : 0;
      endcase
      tie_mode = ($urandom_range(0, 3) == 0);
      err_at   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, SAMPLES_PER_BATCH - 1) : -1;
      for (int k = 0; k < SAMPLES_PER_BATCH; k++) begin
        if (k == err_at) begin
          push_reading($urandom_range(0, SMAX), 1'b1);
          pushed++;
          break;
        end
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, SMAX);
        else if (tie_mode) v = base + ($urandom_range(0, 1) ? 1000 : 0);
        else v = base + int'($urandom_range(0, 4000)) - 2000;
        if (v < 0) v = 0;
        if (v > SMAX) v = SMAX;
        push_reading(v, 1'b0);
        pushed++;
      end
    end
  endtask

  initial begin : stimulus
    int t;
    logic [SAMPLE_W-1:0] ta [NUM_THR];
    for (int k = 0; k < NUM_THR; k++) thr_now[k] = THR_RESET[k];
    factory_now = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, default thresholds
    repeat (SAMPLES_PER_BATCH) push_reading(0, 1'b0);
    repeat (SAMPLES_PER_BATCH) push_reading(SMAX, 1'b0);
    push_reading(500000, 1'b0);
    push_reading(400000, 1'b0);
    push_reading(300000, 1'b0);
    push_reading(200000, 1'b0);
    push_reading(100000, 1'b0);
    repeat (SAMPLES_PER_BATCH) push_reading(250000, 1'b0);
    push_reading(12345, 1'b0);
    push_reading(SMAX, 1'b0);
    push_reading(SMAX, 1'b1);
    push_reading(0, 1'b1);
    drain();

    // default thresholds, factory mode on
    configure(30000, 100000, 210000, 290000, 390000, 750000, 1);
    repeat (SAMPLES_PER_BATCH) push_reading(300000, 1'b0);
    queue_random_batches(PHASE_ITEMS);
    drain();

    configure(0, 0, 0, 0, 0, 0, 1);
    queue_random_batches(PHASE_ITEMS);
    drain();

    // upper bits of the factory write are dropped
    set_reg(CFG_NONE, SAMPLE_W'($urandom_range(0, SMAX)));
    configure(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SAMPLE_W'(SMAX - 1));
    queue_random_batches(PHASE_ITEMS);
    drain();

    for (int k = 0; k < NUM_THR; k++) ta[k] = SAMPLE_W'($urandom_range(0, 900000));
    configure(ta[0], ta[1], ta[2], ta[3], ta[4], ta[5], SAMPLE_W'($urandom_range(0, 1)));
    queue_random_batches(PHASE_ITEMS);
    drain();

    t = $urandom_range(0, 60000);
    for (int k = 0; k < NUM_THR; k++) begin
      ta[k] = SAMPLE_W'(t);
      t += $urandom_range(0, 250000);
    end
    configure(ta[0], ta[1], ta[2], ta[3], ta[4], ta[5], 1);
    queue_random_batches(PHASE_ITEMS);
    drain();

    $display("covered %0d readings and %0d results (%0d from read errors)",
             n_readings, n_results, n_err_result);
    $display("over %0d register settings, with %0d failed checks", n_settings, n_fail);
    if (n_fail == 0 && class_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/idrc_pkg.sv
rtl/core/idrc_ctrl.sv
rtl/core/idrc_dp.sv
rtl/core/id_resistor_trimmed_mean_classifier.sv
rtl/core/idrc_chk.sv
tb/sv/tb_top.sv
